/* src/sorted_array_bound_query_macros.svh */
// Assertion macros used by the checker file.
`ifndef SORTED_ARRAY_BOUND_QUERY_MACROS_SVH
`define SORTED_ARRAY_BOUND_QUERY_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SABQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sabq assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SABQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sabq assertion failed");

`endif

/* src/sabq_pkg.sv */
`default_nettype none

package sabq_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned IDX_W     = 11;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned M_TDATA_W = 24;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN_LO,
    ST_RUN_UP,
    ST_HOLD
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic key_en;       // capture the key
    logic load;         // restart a search over the whole table
    logic step;         // apply one probe result
    logic strict;       // upper-bound test (key < element)
    logic latch_lower;  // keep the finished lower bound
    logic load_out;     // move the result into the output register
    logic append;
    logic clear;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic busy;      // search window not yet empty
    logic out_free;  // output register can take a result this cycle
  } dp_status_t;

endpackage

`default_nettype wire

/* src/sabq_ram.sv */
`default_nettype none

module sabq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/sabq_ctrl.sv */
`default_nettype none

module sabq_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_valid_i,
  input  wire logic [sabq_pkg::CMD_W-1:0]    s_cmd_i,
  output      logic                          s_ready_o,
  input  wire sabq_pkg::dp_status_t          status_i,
  output      sabq_pkg::ctrl_cmd_t           cmd_o
);

  import sabq_pkg::*;

  state_e state_q, state_d;
  logic   accept;
  cmd_e   cmd;

  assign s_ready_o = (state_q == ST_IDLE);
  assign accept    = s_valid_i & s_ready_o;
  assign cmd       = cmd_e'(s_cmd_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (cmd == CMD_QUERY)) begin
          state_d = ST_RUN_LO;
        end
      end
      ST_RUN_LO: begin
        if (!status_i.busy) begin
          state_d = ST_RUN_UP;
        end
      end
      ST_RUN_UP: begin
        if (!status_i.busy) begin
          state_d = status_i.out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_CLEAR:  cmd_o.clear  = 1'b1;
            CMD_APPEND: cmd_o.append = 1'b1;
            CMD_QUERY: begin
              cmd_o.key_en = 1'b1;
              cmd_o.load   = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_RUN_LO: begin
        if (status_i.busy) begin
          cmd_o.step = 1'b1;
        end else begin
          cmd_o.latch_lower = 1'b1;
          cmd_o.load        = 1'b1;
        end
      end
      ST_RUN_UP: begin
        cmd_o.strict = 1'b1;
        if (status_i.busy) begin
          cmd_o.step = 1'b1;
        end else begin
          cmd_o.load_out = status_i.out_free;
        end
      end
      ST_HOLD: begin
        cmd_o.load_out = status_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* src/sabq_dp.sv */
`default_nettype none

module sabq_dp #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire sabq_pkg::ctrl_cmd_t               cmd_i,
  input  wire logic [sabq_pkg::VALUE_W-1:0]      value_i,
  input  wire logic                              m_ready_i,
  output      logic                              m_valid_o,
  output      logic [sabq_pkg::M_TDATA_W-1:0]    m_data_o,
  output      sabq_pkg::dp_status_t              status_o
);

  import sabq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]               count_q, count_d;
  logic [CW-1:0]               lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [CW-1:0]               lower_q;
  logic [CW:0]                 sum;
  logic signed [VALUE_W-1:0]   key_q;
  logic signed [VALUE_W-1:0]   probe;
  logic [VALUE_W-1:0]          rdata;
  logic                        go_left;
  logic                        wr_en;
  logic                        out_valid_q, out_valid_d;
  logic                        out_found_q;
  logic [IDX_W-1:0]            out_lower_q, out_upper_q;

  assign wr_en = cmd_i.append && (count_q < CW'(DEPTH));

  sabq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (value_i),
    .raddr_i (mid_d[AW-1:0]),
    .rdata_o (rdata)
  );

  assign probe   = signed'(rdata);
  assign go_left = cmd_i.strict ? (key_q < probe) : (key_q <= probe);

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (wr_en) begin
      count_d = count_q + CW'(1);
    end
  end

  // Search window; the read address follows the next window so that the
  // registered read data lines up with mid_q.
  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (cmd_i.load) begin
      lo_d = '0;
      hi_d = count_q;
    end else if (cmd_i.step) begin
      if (go_left) begin
        hi_d = mid_q;
      end else begin
        lo_d = mid_q + CW'(1);
      end
    end
    sum   = {1'b0, lo_d} + {1'b0, hi_d};
    mid_d = sum[CW:1];
  end

  assign out_valid_d = cmd_i.load_out ? 1'b1 : (m_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mid_q <= mid_d;
    if (cmd_i.key_en) begin
      key_q <= signed'(value_i);
    end
    if (cmd_i.latch_lower) begin
      lower_q <= lo_q;
    end
    if (cmd_i.load_out) begin
      out_found_q <= (lower_q != lo_q);
      out_lower_q <= IDX_W'(lower_q);
      out_upper_q <= IDX_W'(lo_q);
    end
  end

  assign status_o.busy     = (lo_q < hi_q);
  assign status_o.out_free = !out_valid_q || m_ready_i;

  assign m_valid_o = out_valid_q;
  assign m_data_o  = {1'b0, out_upper_q, out_lower_q, out_found_q};

endmodule

`default_nettype wire

/* src/sorted_array_bound_query.sv */
// Sorted table bound query. The block keeps up to DEPTH signed 32-bit elements,
// which the user must append in ascending order (the block does not check it),
// and answers lower-bound / upper-bound queries by two binary searches over
// them. Commands arrive on the slave stream with the command in tuser (0 clear,
// 1 append, 2 query, 3 ignored) and the element or key in tdata. Appends to a
// full table are dropped. A query produces one transaction on the master stream
// carrying found, the lower index and the upper index. A query occupies the
// block through a lower and then an upper search, each making at most
// floor(log2(count)) + 1 probes (11 for a full 1024-entry table); the single
// element RAM delivers one registered read per probe. A finished result sits in
// an output register, so the next command is taken while that result still
// waits to be collected; a second result waits in the search registers, with
// the controller holding, until the register frees up. The element RAM is not
// cleared at reset: only entries below the element count are ever probed, and
// those have all been written since the last clear.
`default_nettype none

module sorted_array_bound_query #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // slave stream
  input  wire logic                              s_axis_tvalid_i,
  output      logic                              s_axis_tready_o,
  input  wire logic [sabq_pkg::S_TDATA_W-1:0]    s_axis_tdata_i,  // [31:0] value
  input  wire logic [sabq_pkg::CMD_W-1:0]        s_axis_tuser_i,  // [1:0] command
  // master stream
  output      logic                              m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // [0] found, [11:1] lower_index, [22:12] upper_index, [23] zero
  output      logic [sabq_pkg::M_TDATA_W-1:0]    m_axis_tdata_o
);

  import sabq_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer: idles waiting for a command, then walks the lower and upper
  // searches one probe per cycle, then hands the result to the output register once it is free.
  sabq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_cmd_i   (s_axis_tuser_i),
    .s_ready_o (s_axis_tready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // Element RAM, count, search window, key compare and output register.
  sabq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .value_i   (s_axis_tdata_i),
    .m_ready_i (m_axis_tready_i),
    .m_valid_o (m_axis_tvalid_o),
    .m_data_o  (m_axis_tdata_o),
    .status_o  (status)
  );

endmodule

`default_nettype wire

/* src/sorted_array_bound_query_checker.sv */
`default_nettype none

`include "sorted_array_bound_query_macros.svh"

module sorted_array_bound_query_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tvalid_i,
  input wire logic                              s_axis_tready_o,
  input wire logic [sabq_pkg::CMD_W-1:0]        s_axis_tuser_i,
  input wire logic                              m_axis_tvalid_o,
  input wire logic                              m_axis_tready_i,
  input wire logic [sabq_pkg::M_TDATA_W-1:0]    m_axis_tdata_o
);

  import sabq_pkg::*;

  logic s_acc;
  logic is_query;
  logic stall;
  logic found_ok;

  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign is_query = (s_axis_tuser_i == CMD_QUERY);
  assign stall    = m_axis_tvalid_o && !m_axis_tready_i;
  assign found_ok = m_axis_tdata_o[0] == (m_axis_tdata_o[11:1] != m_axis_tdata_o[22:12]);

  // Hold a stalled result unchanged
  `SABQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, stall, m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // Found flag agrees with the two indices
  `SABQ_ASSERT_NOW(a_found, clk_i, rst_ni, m_axis_tvalid_o, found_ok)

  // A query occupies the block for at least the following cycle
  `SABQ_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, s_acc && is_query, !s_axis_tready_o)

  // Clear, append and unused codes leave the block ready again in the next cycle
  `SABQ_ASSERT_NEXT(a_cmd_single, clk_i, rst_ni, s_acc && !is_query, s_axis_tready_o)

endmodule

bind sorted_array_bound_query sorted_array_bound_query_checker u_checker (.*);

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import sabq_pkg::*;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;  // command code the block ignores
  localparam int unsigned ITEM_TARGET = 1400;
  localparam int unsigned QUIET_FROM = 1250;       // no random idling on either side after this
  localparam int unsigned FULL_FILL_AT = 150;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned N_DIRECTED = 21;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] lower;
    logic [IDX_W-1:0] upper;
  } bound_result_t;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
    bit                 typed;  // expected result written into the row
    bound_result_t      want;
  } stim_row_t;

  localparam bound_result_t NO_BOUNDS = '0;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i;   // [31:0] value
  logic [CMD_W-1:0]     s_axis_tuser_i;   // [1:0] command
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;   // [0] found, [11:1] lower, [22:12] upper, [23] zero

  sorted_array_bound_query #(
    .DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // Shadow of the element table and its fill level.
  logic signed [VALUE_W-1:0] table_copy [TABLE_DEPTH];
  int unsigned               held_count;

  bound_result_t pending_bounds [$];
  int unsigned   mismatch_count;
  int unsigned   items_issued;
  bit            quiet_tail;
  bit            sender_steady;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

  // Binary search with the block's probe order; strict selects the upper bound.
  function automatic int unsigned locate_bound(logic signed [VALUE_W-1:0] key, bit strict);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    bit          go_left;
    lo = 0;
    hi = held_count;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      go_left = strict ? (key < table_copy[mid]) : (key <= table_copy[mid]);
      if (go_left) begin
        hi = mid;
      end else begin
        lo = mid + 1;
      end
    end
    return lo;
  endfunction

  // Advance the shadow state for one accepted command; queue the answer of a query.
  task automatic apply_command(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value,
                               bit typed, bound_result_t want);
    int unsigned   lo;
    int unsigned   up;
    bound_result_t answer;
    case (cmd)
      CMD_CLEAR: begin
        held_count = 0;
      end
      CMD_APPEND: begin
        // drop appends to a full table
        if (held_count < TABLE_DEPTH) begin
          table_copy[held_count] = value;
          held_count++;
        end
      end
      CMD_QUERY: begin
        lo = locate_bound(value, 1'b0);
        up = locate_bound(value, 1'b1);
        answer.found = (lo != up);
        answer.lower = lo[IDX_W-1:0];
        answer.upper = up[IDX_W-1:0];
        pending_bounds.push_back(typed ? want : answer);
      end
      default: ;
    endcase
  endtask

  // Present one command and hold it until the block takes the transaction.
  task automatic issue(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value,
                       bit typed, bound_result_t want);
    if (!quiet_tail && !sender_steady && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    s_axis_tuser_i  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    apply_command(cmd, value, typed, want);
    if (cmd != CMD_UNUSED) items_issued++;
  endtask

  // Hold the sender until every outstanding query has been answered.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_bounds.size() != 0);
  endtask

  // Keys cluster on stored elements and their neighbours, with extremes and noise.
  function automatic logic [VALUE_W-1:0] pick_key();
    logic [VALUE_W-1:0] hit;
    hit = (held_count > 0) ? table_copy[$urandom_range(0, held_count - 1)] : $urandom;
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return $urandom;
      5:       return hit + 32'd1;
      6:       return hit - 32'd1;
      default: return hit;
    endcase
  endfunction

  // Result side: random back-pressure, then compare each transaction with the oldest answer.
  initial begin : result_sink
    int unsigned   stall_left;
    bound_result_t got;
    bound_result_t want;
    stall_left = 0;
    m_axis_tready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.found = m_axis_tdata_o[0];
        got.lower = m_axis_tdata_o[11:1];
        got.upper = m_axis_tdata_o[22:12];
        if (pending_bounds.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result with no query outstanding: found=%0b lower=%0d upper=%0d",
                     $realtime, got.found, got.lower, got.upper);
        end else begin
          want = pending_bounds.pop_front();
          if (got.found !== want.found || got.lower !== want.lower ||
              got.upper !== want.upper || m_axis_tdata_o[23] !== 1'b0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: bound mismatch: expected found=%0b lower=%0d upper=%0d",
                       $realtime, want.found, want.lower, want.upper);
              $display("  got found=%0b lower=%0d upper=%0d pad=%0b",
                       got.found, got.lower, got.upper, m_axis_tdata_o[23]);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 16);
      end
      m_axis_tready_i <= (stall_left == 0);
    end
  end

  initial begin : command_source
    stim_row_t   directed_rows [N_DIRECTED];
    longint      next_elem;
    int unsigned n_append;
    int unsigned n_query;
    int unsigned segment;
    bit          sorted_run;

    held_count      = 0;
    mismatch_count  = 0;
    items_issued    = 0;
    quiet_tail      = 1'b0;
    sender_steady   = 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= CMD_CLEAR;

    directed_rows = '{
      // empty table after reset
      '{CMD_QUERY,  32'h8000_0000, 1'b1, '{1'b0, 11'd0, 11'd0}},
      '{CMD_QUERY,  32'h7fff_ffff, 1'b1, '{1'b0, 11'd0, 11'd0}},
      // extremes with a duplicated zero
      '{CMD_APPEND, 32'h8000_0000, 1'b0, NO_BOUNDS},
      '{CMD_APPEND, 32'hffff_ffff, 1'b0, NO_BOUNDS},
      '{CMD_APPEND, 32'h0000_0000, 1'b0, NO_BOUNDS},
      '{CMD_APPEND, 32'h0000_0000, 1'b0, NO_BOUNDS},
      '{CMD_APPEND, 32'h7fff_ffff, 1'b0, NO_BOUNDS},
      '{CMD_QUERY,  32'h8000_0000, 1'b1, '{1'b1, 11'd0, 11'd1}},
      '{CMD_QUERY,  32'h7fff_ffff, 1'b1, '{1'b1, 11'd4, 11'd5}},
      '{CMD_QUERY,  32'h0000_0000, 1'b1, '{1'b1, 11'd2, 11'd4}},
      '{CMD_QUERY,  32'h0000_0001, 1'b0, NO_BOUNDS},
      '{CMD_QUERY,  32'hffff_fffe, 1'b0, NO_BOUNDS},
      // ignored code leaves the table alone
      '{CMD_UNUSED, 32'hffff_ffff, 1'b0, NO_BOUNDS},
      '{CMD_QUERY,  32'hffff_ffff, 1'b0, NO_BOUNDS},
      '{CMD_CLEAR,  32'h5555_aaaa, 1'b0, NO_BOUNDS},
      '{CMD_QUERY,  32'h0000_0000, 1'b1, '{1'b0, 11'd0, 11'd0}},
      // out-of-order table
      '{CMD_APPEND, 32'h0000_0009, 1'b0, NO_BOUNDS},
      '{CMD_APPEND, 32'h0000_0003, 1'b0, NO_BOUNDS},
      '{CMD_APPEND, 32'h0000_0007, 1'b0, NO_BOUNDS},
      '{CMD_QUERY,  32'h0000_0007, 1'b0, NO_BOUNDS},
      '{CMD_QUERY,  32'h0000_0003, 1'b0, NO_BOUNDS}
    };

    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    foreach (directed_rows[i])
      issue(directed_rows[i].cmd, directed_rows[i].value, directed_rows[i].typed,
            directed_rows[i].want);

    segment = 0;
    while (items_issued < ITEM_TARGET) begin
      sender_steady = ($urandom_range(0, 3) == 0);
      if (segment == 0 || $urandom_range(0, 5) == 0) drain_results();

      if (items_issued >= FULL_FILL_AT && held_count < TABLE_DEPTH && segment < 1000) begin
        // one run over the whole table, plus appends that must be dropped
        issue(CMD_CLEAR, $urandom, 1'b0, NO_BOUNDS);
        next_elem = -longint'(TABLE_DEPTH) * 3;
        for (int unsigned i = 0; i < TABLE_DEPTH + 3; i++) begin
          next_elem += $urandom_range(0, 5);
          issue(CMD_APPEND, next_elem[VALUE_W-1:0], 1'b0, NO_BOUNDS);
        end
        for (int unsigned i = 0; i < 24; i++)
          issue(CMD_QUERY, pick_key(), 1'b0, NO_BOUNDS);
        segment = 1000;
      end else begin
        // mostly a clear, an ascending fill of small size and a burst of queries
        if ($urandom_range(0, 7) != 0) issue(CMD_CLEAR, $urandom, 1'b0, NO_BOUNDS);
        n_append   = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 160)
                                                 : $urandom_range(0, 24);
        sorted_run = ($urandom_range(0, 9) != 0);
        case ($urandom_range(0, 3))
          0:       next_elem = -64'sd2147483648;
          1:       next_elem = longint'($urandom_range(0, 200)) - 100;
          default: next_elem = int'($urandom);
        endcase
        for (int unsigned i = 0; i < n_append; i++) begin
          if ($urandom_range(0, 19) == 0) issue(CMD_UNUSED, $urandom, 1'b0, NO_BOUNDS);
          if (sorted_run) begin
            case ($urandom_range(0, 3))
              0:       next_elem += 0;
              3:       next_elem += $urandom_range(1, 1 << 20);
              default: next_elem += $urandom_range(1, 8);
            endcase
            if (next_elem > 64'sd2147483647) next_elem = 64'sd2147483647;
            issue(CMD_APPEND, next_elem[VALUE_W-1:0], 1'b0, NO_BOUNDS);
          end else begin
            issue(CMD_APPEND, $urandom, 1'b0, NO_BOUNDS);
          end
          if (items_issued >= QUIET_FROM) quiet_tail = 1'b1;
        end
        n_query = $urandom_range(1, 12);
        for (int unsigned i = 0; i < n_query; i++) begin
          issue(CMD_QUERY, pick_key(), 1'b0, NO_BOUNDS);
          if (items_issued >= QUIET_FROM) quiet_tail = 1'b1;
        end
        segment++;
      end
      if (items_issued >= QUIET_FROM) quiet_tail = 1'b1;
    end

    // wait out every answer, then let the block settle
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_bounds.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_bounds.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/sabq_pkg.sv
src/sabq_ram.sv
src/sabq_ctrl.sv
src/sabq_dp.sv
src/sorted_array_bound_query.sv
src/sorted_array_bound_query_checker.sv
sim/testbench.sv
